>>> src/mspc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspc_pkg: shared types and constants of the motor speed PWM controller
// Register indexes, limits, the configuration bundle, the gate-event bundle
// and the seven-segment / decimal split helpers.
// ----------------------------------------------------------------------------
package mspc_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_SPEED_HIGH   = 3'd0;
   localparam logic [2:0] CSR_SPEED_LOW    = 3'd1;
   localparam logic [2:0] CSR_GATE_TICKS   = 3'd2;
   localparam logic [2:0] CSR_ADJUST_TICKS = 3'd3;
   localparam logic [2:0] CSR_KEY_TICKS    = 3'd4;
   localparam logic [2:0] CSR_LED_TICKS    = 3'd5;
   localparam logic [2:0] CSR_DIGIT_TICKS  = 3'd6;
   localparam logic [2:0] CSR_PWM_PERIOD   = 3'd7;

   localparam logic [6:0] SETPOINT_MAX   = 7'd99;
   localparam logic [6:0] SETPOINT_RESET = 7'd40;
   localparam logic [6:0] DUTY_MAX       = 7'd99;
   localparam logic [6:0] DUTY_MIN       = 7'd1;
   localparam logic [6:0] SHOWN_MAX      = 7'd99;
   localparam logic [7:0] SEG_BLANK      = 8'hFF;
   localparam logic [7:0] SEL_NONE       = 8'hFF;

   // display positions that the gate event refreshes
   localparam int unsigned STORED_DIGITS = 6;

   typedef struct packed {
      logic [9:0] speed_high;
      logic [9:0] speed_low;
      logic [9:0] gate_ticks;
      logic [9:0] adjust_ticks;
      logic [7:0] key_ticks;
      logic [7:0] led_ticks;
      logic [7:0] digit_ticks;
      logic [6:0] pwm_period;
   } cfg_type;

   // gate window closing: new setpoint and speed clipped for display
   typedef struct packed {
      logic       fire;
      logic [6:0] setpoint;
      logic [6:0] shown;
   } gate_info_type;

   function automatic logic [7:0] seg_code(input logic [3:0] d);
      logic [7:0] c;
      case (d)
         4'd0:    c = 8'hC0;
         4'd1:    c = 8'hF9;
         4'd2:    c = 8'hA4;
         4'd3:    c = 8'hB0;
         4'd4:    c = 8'h99;
         4'd5:    c = 8'h92;
         4'd6:    c = 8'h82;
         4'd7:    c = 8'hF8;
         4'd8:    c = 8'h80;
         4'd9:    c = 8'h90;
         default: c = SEG_BLANK;
      endcase
      return c;
   endfunction

   // tens of a value up to 99: multiply by 205/2048
   function automatic logic [3:0] dec_tens(input logic [6:0] v);
      logic [14:0] p;
      p = 15'(v) * 15'd205;
      return p[14:11];
   endfunction

   function automatic logic [3:0] dec_units(input logic [6:0] v);
      logic [6:0] t10;
      t10 = 7'(dec_tens(v)) * 7'd10;
      return 4'(v - t10);
   endfunction

endpackage

>>> src/motor_speed_pwm_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_speed_pwm_controller_unit: DC motor PWM speed control, top level
// Millisecond tick beats in, one status beat out per tick.
// ----------------------------------------------------------------------------
// Each req beat is one millisecond tick with the tachometer pulse count and
// the three key levels; each produces exactly one rsp beat carrying the PWM
// drive level, the alarm LED level, the multiplexed display drive, setpoint,
// measured speed and duty. A beat sits in an input register, the whole tick
// update (counters, keys, LED, PWM, gate, duty step, display scan) is worked
// out from it, and the result lands in an output register; one beat is taken
// every cycle while the output is not stalled by rsp_tready. The output
// register decouples the sides, so a new req beat is taken while a result
// still waits, and only a full pipe with rsp_tready low holds req_tready low.
// Configuration registers are written through csr_* and should only change
// while no beat is in flight.
// ----------------------------------------------------------------------------
module motor_speed_pwm_controller_unit #(
   parameter int unsigned NUM_DIGITS = 6
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [2:0] tach_pulses, [3] key_down, [4] key_up, [5] key_stop
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [0] motor_enable, [1] alarm_led, [9:2] digit_select,
   // [17:10] segments, [24:18] setpoint, [34:25] measured_speed,
   // [41:35] duty, [47:42] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [9:0]  csr_wdata
);
   import mspc_pkg::*;

   cfg_type       cfg_ff;
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_data_ff;
   logic          out_valid_ff, out_valid_in;
   logic [47:0]   out_data_ff;

   logic          out_free;
   logic          step;
   gate_info_type gate;
   logic          motor_level_in, led_level_in;
   logic [6:0]    target_in, duty_in;
   logic [9:0]    speed_in;
   logic [7:0]    select_in, segments_in;

   // ---- handshake and pipe control ----
   assign out_free     = !out_valid_ff || rsp_tready;
   assign step         = in_valid_ff && out_free;
   assign req_tready   = !in_valid_ff || out_free;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : 1'b1;

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_data_ff <= req_tdata;
      if (step) begin
         out_data_ff <= {6'd0, duty_in, speed_in, target_in, segments_in,
                         select_in, led_level_in, motor_level_in};
      end
   end

   // ---- configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_high   <= 10'd30;
         cfg_ff.speed_low    <= 10'd10;
         cfg_ff.gate_ticks   <= 10'd1000;
         cfg_ff.adjust_ticks <= 10'd999;
         cfg_ff.key_ticks    <= 8'd150;
         cfg_ff.led_ticks    <= 8'd200;
         cfg_ff.digit_ticks  <= 8'd4;
         cfg_ff.pwm_period   <= 7'd100;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SPEED_HIGH:   cfg_ff.speed_high   <= csr_wdata;
            CSR_SPEED_LOW:    cfg_ff.speed_low    <= csr_wdata;
            CSR_GATE_TICKS:   cfg_ff.gate_ticks   <= csr_wdata;
            CSR_ADJUST_TICKS: cfg_ff.adjust_ticks <= csr_wdata;
            CSR_KEY_TICKS:    cfg_ff.key_ticks    <= csr_wdata[7:0];
            CSR_LED_TICKS:    cfg_ff.led_ticks    <= csr_wdata[7:0];
            CSR_DIGIT_TICKS:  cfg_ff.digit_ticks  <= csr_wdata[7:0];
            CSR_PWM_PERIOD:   cfg_ff.pwm_period   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // ---- tick processing ----
   mspc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .cfg            (cfg_ff),
      .tach_pulses    (in_data_ff[2:0]),
      .key_down       (in_data_ff[3]),
      .key_up         (in_data_ff[4]),
      .key_stop       (in_data_ff[5]),
      .gate           (gate),
      .motor_level_in (motor_level_in),
      .led_level_in   (led_level_in),
      .target_in      (target_in),
      .speed_in       (speed_in),
      .duty_in        (duty_in)
   );

   mspc_disp #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_disp (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .digit_ticks (cfg_ff.digit_ticks),
      .gate        (gate),
      .select_in   (select_in),
      .segments_in (segments_in)
   );

   // an accepted beat always lands in the input register
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_valid_ff)
      else $error("accepted beat lost");

   // a processed beat always produces a result
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed beat gave no result");

   // a beat blocked by a full output stays put
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> in_valid_ff && $stable(in_data_ff))
      else $error("stalled beat dropped");

endmodule

>>> src/mspc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspc_core: interval counters, keys, alarm LED, PWM, speed gate, duty step
// Holds the control state and gives its next values for the current beat.
// ----------------------------------------------------------------------------
module mspc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  mspc_pkg::cfg_type     cfg,
   input  logic [2:0]            tach_pulses,
   input  logic                  key_down,
   input  logic                  key_up,
   input  logic                  key_stop,
   output mspc_pkg::gate_info_type gate,
   output logic                  motor_level_in,
   output logic                  led_level_in,
   output logic [6:0]            target_in,
   output logic [9:0]            speed_in,
   output logic [6:0]            duty_in
);
   import mspc_pkg::*;

   logic [9:0] gate_count_ff, gate_count_in;
   logic [9:0] adjust_count_ff, adjust_count_in;
   logic [7:0] key_count_ff, key_count_in;
   logic [7:0] led_count_ff, led_count_in;
   logic [6:0] pwm_count_ff, pwm_count_in;
   logic [9:0] accum_ff, accum_in;
   logic [9:0] speed_ff;
   logic [6:0] target_ff;
   logic [6:0] duty_ff;
   logic       led_level_ff;
   logic       motor_level_ff;

   logic [9:0]  gate_inc, adjust_inc;
   logic [7:0]  key_inc, led_inc;
   logic [6:0]  pwm_inc;
   logic [10:0] accum_sum;
   logic        gate_fire;

   always_comb begin
      gate_inc   = (&gate_count_ff)   ? gate_count_ff   : gate_count_ff + 10'd1;
      adjust_inc = (&adjust_count_ff) ? adjust_count_ff : adjust_count_ff + 10'd1;
      key_inc    = (&key_count_ff)    ? key_count_ff    : key_count_ff + 8'd1;
      led_inc    = (&led_count_ff)    ? led_count_ff    : led_count_ff + 8'd1;
      pwm_inc    = (&pwm_count_ff)    ? pwm_count_ff    : pwm_count_ff + 7'd1;
      accum_sum  = 11'(accum_ff) + 11'(tach_pulses);

      gate_count_in   = gate_count_ff;
      adjust_count_in = adjust_count_ff;
      key_count_in    = key_count_ff;
      led_count_in    = led_count_ff;
      pwm_count_in    = pwm_count_ff;
      accum_in        = accum_ff;
      speed_in        = speed_ff;
      target_in       = target_ff;
      duty_in         = duty_ff;
      led_level_in    = led_level_ff;
      motor_level_in  = motor_level_ff;
      gate_fire       = 1'b0;

      if (step) begin
         gate_count_in   = gate_inc;
         adjust_count_in = adjust_inc;
         key_count_in    = key_inc;
         led_count_in    = led_inc;
         pwm_count_in    = pwm_inc;
         accum_in        = accum_sum[10] ? 10'h3FF : accum_sum[9:0];

         // keys: down beats up, up beats stop
         if (key_inc >= cfg.key_ticks) begin
            key_count_in = '0;
            if (key_down) begin
               if (target_ff != 7'd0) target_in = target_ff - 7'd1;
            end else if (key_up) begin
               if (target_ff < SETPOINT_MAX) target_in = target_ff + 7'd1;
            end else if (key_stop) begin
               target_in = '0;
            end
         end

         // alarm LED sees the speed of the previous gate
         if (led_inc >= cfg.led_ticks) begin
            led_count_in = '0;
            if (speed_ff > cfg.speed_high || speed_ff < cfg.speed_low) begin
               led_level_in = ~led_level_ff;
            end else begin
               led_level_in = 1'b1;
            end
         end

         // PWM compares against the duty held before this beat's step
         if (pwm_inc >= cfg.pwm_period) begin
            pwm_count_in   = '0;
            motor_level_in = 1'b1;
         end else if (pwm_inc == duty_ff) begin
            motor_level_in = 1'b0;
         end

         if (gate_inc >= cfg.gate_ticks) begin
            gate_count_in = '0;
            gate_fire     = 1'b1;
            speed_in      = accum_in;
            accum_in      = '0;
         end

         if (adjust_inc >= cfg.adjust_ticks) begin
            adjust_count_in = '0;
            if (11'(speed_in) > 11'(target_in) + 11'd1) begin
               if (duty_ff < DUTY_MAX) duty_in = duty_ff + 7'd1;
            end else if (11'(speed_in) + 11'd1 < 11'(target_in)) begin
               if (duty_ff > DUTY_MIN) duty_in = duty_ff - 7'd1;
            end
         end
      end

      gate.fire     = gate_fire;
      gate.setpoint = target_in;
      gate.shown    = (speed_in > 10'(SHOWN_MAX)) ? SHOWN_MAX : speed_in[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_count_ff   <= '0;
         adjust_count_ff <= '0;
         key_count_ff    <= '0;
         led_count_ff    <= '0;
         pwm_count_ff    <= '0;
         accum_ff        <= '0;
         speed_ff        <= '0;
         target_ff       <= SETPOINT_RESET;
         duty_ff         <= DUTY_MAX;
         led_level_ff    <= 1'b1;
         motor_level_ff  <= 1'b1;
      end else begin
         gate_count_ff   <= gate_count_in;
         adjust_count_ff <= adjust_count_in;
         key_count_ff    <= key_count_in;
         led_count_ff    <= led_count_in;
         pwm_count_ff    <= pwm_count_in;
         accum_ff        <= accum_in;
         speed_ff        <= speed_in;
         target_ff       <= target_in;
         duty_ff         <= duty_in;
         led_level_ff    <= led_level_in;
         motor_level_ff  <= motor_level_in;
      end
   end

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      duty_ff >= DUTY_MIN && duty_ff <= DUTY_MAX)
      else $error("duty left its range");

   a_target_range: assert property (@(posedge clock) disable iff (reset)
      target_ff <= SETPOINT_MAX)
      else $error("setpoint above limit");

   a_speed_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(speed_ff) && $stable(duty_ff) && $stable(target_ff))
      else $error("control state moved without a beat");

endmodule

>>> src/mspc_disp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspc_disp: seven-segment digit store and display multiplexer
// Refreshes the store on a gate event and scans one digit per interval.
// ----------------------------------------------------------------------------
module mspc_disp #(
   parameter int unsigned NUM_DIGITS = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              digit_ticks,
   input  mspc_pkg::gate_info_type gate,
   output logic [7:0]              select_in,
   output logic [7:0]              segments_in
);
   import mspc_pkg::*;

   localparam int unsigned IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   logic [7:0]       store_ff [NUM_DIGITS];
   logic [7:0]       store_in [NUM_DIGITS];
   logic [IDX_W-1:0] index_ff, index_in;
   logic [7:0]       count_ff, count_in;
   logic [7:0]       select_ff, segments_ff;

   logic [7:0]       count_inc;
   logic [IDX_W-1:0] cur;
   logic [IDX_W:0]   nxt;

   function automatic logic [7:0] digit_code(input int unsigned pos,
                                             input gate_info_type g);
      logic [7:0] c;
      case (pos)
         0:       c = seg_code(dec_units(g.shown));
         1:       c = seg_code(dec_tens(g.shown));
         3:       c = seg_code(dec_units(g.setpoint));
         4:       c = seg_code(dec_tens(g.setpoint));
         default: c = SEG_BLANK;
      endcase
      return c;
   endfunction

   always_comb begin
      for (int unsigned p = 0; p < NUM_DIGITS; p++) begin
         store_in[p] = (step && gate.fire && p < STORED_DIGITS) ? digit_code(p, gate)
                                                                  : store_ff[p];
      end

      count_inc   = (&count_ff) ? count_ff : count_ff + 8'd1;
      cur         = (32'(index_ff) >= NUM_DIGITS) ? '0 : index_ff;
      nxt         = (IDX_W + 1)'(cur) + (IDX_W + 1)'(1);
      count_in    = count_ff;
      index_in    = index_ff;
      select_in   = select_ff;
      segments_in = segments_ff;

      if (step) begin
         count_in = count_inc;
         if (count_inc >= digit_ticks) begin
            count_in    = '0;
            select_in   = ~(8'd1 << cur);
            segments_in = store_in[cur];
            index_in    = (32'(nxt) >= NUM_DIGITS) ? '0 : nxt[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int unsigned p = 0; p < NUM_DIGITS; p++) store_ff[p] <= '0;
         index_ff    <= '0;
         count_ff    <= '0;
         select_ff   <= SEL_NONE;
         segments_ff <= SEG_BLANK;
      end else begin
         for (int unsigned p = 0; p < NUM_DIGITS; p++) store_ff[p] <= store_in[p];
         index_ff    <= index_in;
         count_ff    <= count_in;
         select_ff   <= select_in;
         segments_ff <= segments_in;
      end
   end

endmodule

>>> test/motor_speed_pwm_controller_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_speed_pwm_controller_unit_test: tick stream check of the PWM speed unit
// Drives millisecond tick beats with pulse counts and key levels, predicts
// each status beat from a local model of counters, keys, LED, PWM, gate, duty
// step and display scan, and compares every status beat field by field.
// Runs a short table first, then random ticks under several register sets.
// ----------------------------------------------------------------------------
module motor_speed_pwm_controller_unit_test;
   import mspc_pkg::*;

   localparam int unsigned DIGITS   = 6;
   localparam int unsigned FAST_ROW = 8;      // table rows from here run on fast intervals
   localparam int unsigned REPORTS  = 10;
   localparam int unsigned HOLD_LEN = 40;     // long receiver hold-off, in cycles

   // one status beat, as the predictor and the checker see it
   typedef struct packed {
      logic       motor_enable;
      logic       alarm_led;
      logic [7:0] digit_select;
      logic [7:0] segments;
      logic [6:0] setpoint;
      logic [9:0] measured_speed;
      logic [6:0] duty;
   } status_type;

   typedef struct {
      logic [2:0] pulses;
      logic       key_down;
      logic       key_up;
      logic       key_stop;
      bit         typed;      // expected status written in by hand
      status_type want;
   } tick_row_type;

   typedef enum int {KEYS_ANY, KEYS_UP, KEYS_DOWN} key_mix_type;

   localparam status_type RESET_VIEW = '{1'b1, 1'b1, SEL_NONE, SEG_BLANK,
                                         SETPOINT_RESET, 10'd0, DUTY_MAX};
   // first scan steps: store still all zero after reset
   localparam status_type SCAN0_VIEW = '{1'b1, 1'b1, 8'hFE, 8'h00,
                                         SETPOINT_RESET, 10'd0, DUTY_MAX};
   localparam status_type SCAN1_VIEW = '{1'b1, 1'b1, 8'hFD, 8'h00,
                                         SETPOINT_RESET, 10'd0, DUTY_MAX};

   // ------------------------------------------------------------------------
   // DUT signals, all inputs known from time zero
   // ------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // req_tdata: [2:0] tach_pulses, [3] key_down, [4] key_up, [5] key_stop
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // rsp_tdata: [0] motor_enable, [1] alarm_led, [9:2] digit_select,
   // [17:10] segments, [24:18] setpoint, [34:25] measured_speed, [41:35] duty
   logic [47:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [9:0]  csr_wdata  = '0;

   motor_speed_pwm_controller_unit #(
      .NUM_DIGITS (DIGITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor state: own copy of the registers and the tick state
   // ------------------------------------------------------------------------
   cfg_type    ctl_cfg;
   logic [9:0] gate_cnt, adjust_cnt;
   logic [7:0] key_cnt, led_cnt, digit_cnt;
   logic [6:0] pwm_cnt;
   logic [9:0] pulse_sum, speed_now;
   logic [6:0] target_now, duty_now;
   logic       led_now, motor_now;
   logic [2:0] scan_pos;
   logic [7:0] digit_mem [DIGITS];
   logic [7:0] sel_now, seg_now;

   status_type status_due [$];     // expected status beats, oldest first
   int         fault_count = 0;

   // handed from the sender to the checker with each offered beat
   bit         beat_typed = 1'b0;
   status_type beat_want  = '0;

   // idling, in cycles per hundred; hold_left is counted down by the receiver
   int send_idle_pct = 11;
   int recv_idle_pct = 49;
   int hold_left     = 0;

   function automatic logic [7:0] digit_glyph(input int d);
      case (d)
         0:       return 8'hC0;
         1:       return 8'hF9;
         2:       return 8'hA4;
         3:       return 8'hB0;
         4:       return 8'h99;
         5:       return 8'h92;
         6:       return 8'h82;
         7:       return 8'hF8;
         8:       return 8'h80;
         default: return 8'h90;
      endcase
   endfunction

   // One millisecond tick: advance counters, then keys, LED, PWM, gate,
   // duty step and display scan, in that order.
   task automatic predict_tick(input logic [7:0] beat, output status_type st);
      logic [10:0] acc;
      int          shown;
      int          diff;
      gate_cnt   = (gate_cnt   < 10'd1023) ? gate_cnt   + 10'd1 : gate_cnt;
      adjust_cnt = (adjust_cnt < 10'd1023) ? adjust_cnt + 10'd1 : adjust_cnt;
      key_cnt    = (key_cnt    < 8'd255)   ? key_cnt    + 8'd1  : key_cnt;
      led_cnt    = (led_cnt    < 8'd255)   ? led_cnt    + 8'd1  : led_cnt;
      digit_cnt  = (digit_cnt  < 8'd255)   ? digit_cnt  + 8'd1  : digit_cnt;
      pwm_cnt    = (pwm_cnt    < 7'd127)   ? pwm_cnt    + 7'd1  : pwm_cnt;
      acc        = {1'b0, pulse_sum} + 11'(beat[2:0]);
      pulse_sum  = (acc > 11'd1023) ? 10'd1023 : acc[9:0];

      // keys: down beats up, up beats stop
      if (key_cnt >= ctl_cfg.key_ticks) begin
         key_cnt = '0;
         if (beat[3]) begin
            if (target_now > 7'd0) target_now = target_now - 7'd1;
         end else if (beat[4]) begin
            if (target_now < SETPOINT_MAX) target_now = target_now + 7'd1;
         end else if (beat[5]) begin
            target_now = '0;
         end
      end

      if (led_cnt >= ctl_cfg.led_ticks) begin
         led_cnt = '0;
         if (speed_now > ctl_cfg.speed_high || speed_now < ctl_cfg.speed_low)
            led_now = ~led_now;
         else
            led_now = 1'b1;
      end

      if (pwm_cnt >= ctl_cfg.pwm_period) begin
         pwm_cnt   = '0;
         motor_now = 1'b1;
      end else if (pwm_cnt == duty_now) begin
         motor_now = 1'b0;
      end

      // gate closes: latch speed, refresh the display store
      if (gate_cnt >= ctl_cfg.gate_ticks) begin
         gate_cnt     = '0;
         speed_now    = pulse_sum;
         pulse_sum    = '0;
         shown        = (speed_now > 10'd99) ? 99 : int'(speed_now);
         digit_mem[5] = SEG_BLANK;
         digit_mem[4] = digit_glyph((int'(target_now) / 10) % 10);
         digit_mem[3] = digit_glyph(int'(target_now) % 10);
         digit_mem[2] = SEG_BLANK;
         digit_mem[1] = digit_glyph((shown / 10) % 10);
         digit_mem[0] = digit_glyph(shown % 10);
      end

      if (adjust_cnt >= ctl_cfg.adjust_ticks) begin
         adjust_cnt = '0;
         diff = int'(speed_now) - int'(target_now);
         if (diff > 1) begin
            if (duty_now < DUTY_MAX) duty_now = duty_now + 7'd1;
         end else if (diff < -1) begin
            if (duty_now > DUTY_MIN) duty_now = duty_now - 7'd1;
         end
      end

      if (digit_cnt >= ctl_cfg.digit_ticks) begin
         digit_cnt = '0;
         if (scan_pos >= DIGITS) scan_pos = '0;
         sel_now  = ~(8'd1 << scan_pos);
         seg_now  = digit_mem[scan_pos];
         scan_pos = scan_pos + 3'd1;
         if (scan_pos >= DIGITS) scan_pos = '0;
      end

      st = '{motor_now, led_now, sel_now, seg_now, target_now, speed_now, duty_now};
   endtask

   // ------------------------------------------------------------------------
   // Checker: all handshakes seen at the rising edge, pre-edge values.
   // Results are popped before the new beat is pushed; a result never
   // belongs to the beat accepted at the same edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch
      status_type got;
      status_type want;
      status_type predicted;
      if (reset) begin
         ctl_cfg    = '{10'd30, 10'd10, 10'd1000, 10'd999, 8'd150, 8'd200, 8'd4, 7'd100};
         gate_cnt   = '0;
         adjust_cnt = '0;
         key_cnt    = '0;
         led_cnt    = '0;
         digit_cnt  = '0;
         pwm_cnt    = '0;
         pulse_sum  = '0;
         speed_now  = '0;
         target_now = SETPOINT_RESET;
         duty_now   = DUTY_MAX;
         led_now    = 1'b1;
         motor_now  = 1'b1;
         scan_pos   = '0;
         for (int k = 0; k < DIGITS; k++) digit_mem[k] = 8'h00;
         sel_now    = SEL_NONE;
         seg_now    = SEG_BLANK;
         status_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[0], rsp_tdata[1], rsp_tdata[9:2], rsp_tdata[17:10],
                    rsp_tdata[24:18], rsp_tdata[34:25], rsp_tdata[41:35]};
            if (status_due.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORTS)
                  $display("status beat with nothing expected: %h", rsp_tdata);
            end else begin
               want = status_due.pop_front();
               if (got !== want) begin
                  fault_count++;
                  if (fault_count <= REPORTS) begin
                     $display("status mismatch (exp/got): motor %b/%b led %b/%b sel %h/%h",
                              want.motor_enable, got.motor_enable,
                              want.alarm_led, got.alarm_led,
                              want.digit_select, got.digit_select);
                     $display("   seg %h/%h set %0d/%0d speed %0d/%0d duty %0d/%0d",
                              want.segments, got.segments,
                              want.setpoint, got.setpoint,
                              want.measured_speed, got.measured_speed,
                              want.duty, got.duty);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_tick(req_tdata, predicted);
            status_due.push_back(beat_typed ? beat_want : predicted);
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_SPEED_HIGH:   ctl_cfg.speed_high   = csr_wdata;
               CSR_SPEED_LOW:    ctl_cfg.speed_low    = csr_wdata;
               CSR_GATE_TICKS:   ctl_cfg.gate_ticks   = csr_wdata;
               CSR_ADJUST_TICKS: ctl_cfg.adjust_ticks = csr_wdata;
               CSR_KEY_TICKS:    ctl_cfg.key_ticks    = csr_wdata[7:0];
               CSR_LED_TICKS:    ctl_cfg.led_ticks    = csr_wdata[7:0];
               CSR_DIGIT_TICKS:  ctl_cfg.digit_ticks  = csr_wdata[7:0];
               CSR_PWM_PERIOD:   ctl_cfg.pwm_period   = csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random back-pressure, or a long hold-off when asked for
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender side helpers
   // ------------------------------------------------------------------------
   // offer one tick beat after a random gap, return once it is taken
   task automatic send_tick(input logic [7:0] beat, input bit typed, input status_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      beat_typed <= typed;
      beat_want  <= want;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering and wait until every status beat is back
   task automatic drain_status();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= 10'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic apply_settings(input int hi, input int lo, input int gate, input int adj,
                                 input int keys, input int led, input int dig, input int pwm);
      csr_write(CSR_SPEED_HIGH, hi);
      csr_write(CSR_SPEED_LOW, lo);
      csr_write(CSR_GATE_TICKS, gate);
      csr_write(CSR_ADJUST_TICKS, adj);
      csr_write(CSR_KEY_TICKS, keys);
      csr_write(CSR_LED_TICKS, led);
      csr_write(CSR_DIGIT_TICKS, dig);
      csr_write(CSR_PWM_PERIOD, pwm);
   endtask

   function automatic logic [7:0] random_beat(input key_mix_type mix, input int pmin,
                                              input int pmax);
      logic [2:0] p;
      logic       d, u, s;
      int         r;
      p = 3'($urandom_range(pmin, pmax));
      r = $urandom_range(0, 99);
      case (mix)
         KEYS_UP: begin
            d = (r < 5);
            u = (r < 85);
            s = ($urandom_range(0, 3) == 0);
         end
         KEYS_DOWN: begin
            d = (r < 80);
            u = ($urandom_range(0, 1) == 0);
            s = ($urandom_range(0, 3) == 0);
         end
         default: begin
            d = ($urandom_range(0, 3) == 0);
            u = ($urandom_range(0, 3) == 0);
            s = ($urandom_range(0, 3) == 0);
         end
      endcase
      return {2'b00, s, u, d, p};
   endfunction

   task automatic run_ticks(input int count, input key_mix_type mix, input int pmin,
                            input int pmax);
      for (int n = 0; n < count; n++)
         send_tick(random_beat(mix, pmin, pmax), 1'b0, '0);
   endtask

   function automatic tick_row_type mk_row(input int p, input bit d, input bit u, input bit s,
                                           input bit typed, input status_type want);
      tick_row_type r;
      r.pulses   = 3'(p);
      r.key_down = d;
      r.key_up   = u;
      r.key_stop = s;
      r.typed    = typed;
      r.want     = want;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   tick_row_type tick_table [24];

   initial begin
      int w;

      // first rows run on the reset intervals: only the scan moves (every 4 ticks)
      tick_table[0]  = mk_row(7, 1, 1, 1, 1, RESET_VIEW);
      tick_table[1]  = mk_row(0, 0, 0, 0, 1, RESET_VIEW);
      tick_table[2]  = mk_row(5, 0, 1, 0, 1, RESET_VIEW);
      tick_table[3]  = mk_row(0, 1, 0, 0, 1, SCAN0_VIEW);
      tick_table[4]  = mk_row(7, 0, 0, 1, 1, SCAN0_VIEW);
      tick_table[5]  = mk_row(2, 0, 0, 0, 1, SCAN0_VIEW);
      tick_table[6]  = mk_row(0, 0, 1, 1, 1, SCAN0_VIEW);
      tick_table[7]  = mk_row(1, 0, 0, 0, 1, SCAN1_VIEW);
      // fast intervals: keys every tick, priority and the setpoint floor
      tick_table[8]  = mk_row(0, 1, 0, 0, 0, '0);
      tick_table[9]  = mk_row(7, 0, 1, 0, 0, '0);
      tick_table[10] = mk_row(7, 0, 1, 0, 0, '0);
      tick_table[11] = mk_row(0, 0, 0, 1, 0, '0);
      tick_table[12] = mk_row(3, 1, 0, 0, 0, '0);
      tick_table[13] = mk_row(7, 1, 1, 0, 0, '0);
      tick_table[14] = mk_row(0, 0, 1, 1, 0, '0);
      tick_table[15] = mk_row(7, 0, 1, 1, 0, '0);
      tick_table[16] = mk_row(0, 1, 1, 1, 0, '0);
      tick_table[17] = mk_row(7, 0, 0, 1, 0, '0);
      tick_table[18] = mk_row(7, 0, 0, 0, 0, '0);
      tick_table[19] = mk_row(7, 0, 1, 0, 0, '0);
      tick_table[20] = mk_row(0, 0, 0, 0, 0, '0);
      tick_table[21] = mk_row(4, 1, 0, 0, 0, '0);
      tick_table[22] = mk_row(6, 0, 0, 0, 0, '0);
      tick_table[23] = mk_row(0, 0, 0, 0, 0, '0);

      // reset held from time zero, then released once
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // -- directed table; sender idles 11 %, receiver 49 %
      foreach (tick_table[i]) begin
         if (i == FAST_ROW) begin
            drain_status();
            apply_settings(30, 10, 2, 1, 1, 1, 1, 4);
         end
         send_tick({2'b00, tick_table[i].key_stop, tick_table[i].key_up,
                    tick_table[i].key_down, tick_table[i].pulses},
                   tick_table[i].typed, tick_table[i].want);
      end
      drain_status();

      // -- moderate intervals; long receiver hold-off while the sender keeps
      //    offering, then a sender pause until all status is back
      apply_settings(30, 10, 8, 3, 2, 3, 1, 10);
      run_ticks(30, KEYS_ANY, 0, 7);
      hold_left = HOLD_LEN;
      run_ticks(30, KEYS_ANY, 0, 7);
      drain_status();
      run_ticks(20, KEYS_ANY, 0, 7);
      drain_status();

      // -- shortest intervals, alarm window closed at zero; keys push the
      //    setpoint to its ceiling, duty walks down to its floor
      apply_settings(0, 0, 1, 1, 1, 1, 1, 2);
      run_ticks(100, KEYS_UP, 0, 7);
      drain_status();

      // -- sender idles 49 %, receiver 11 %
      send_idle_pct = 49;
      recv_idle_pct = 11;

      // -- zero intervals but a PWM period of 2: the other jobs run on every tick; setpoint to zero, duty up
      apply_settings(1023, 1023, 0, 0, 0, 0, 0, 2);
      run_ticks(100, KEYS_DOWN, 0, 3);
      drain_status();

      // -- long gate with full pulse counts, longest 8-bit intervals and the
      //    longest PWM period: the accumulator saturates on the way
      apply_settings(1023, 0, 1023, 1023, 255, 255, 255, 127);
      run_ticks(270, KEYS_ANY, 7, 7);
      drain_status();

      // -- no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;

      // -- short gate latches the saturated speed on the next tick
      apply_settings(40, 20, 10, 2, 3, 2, 2, 50);
      run_ticks(60, KEYS_ANY, 0, 7);

      // -- wind down: wait for the last status, then the pipe latency
      @(negedge clock);
      req_tvalid <= 1'b0;
      for (w = 0; w < 5000 && status_due.size() != 0; w++) @(posedge clock);
      repeat (4) @(posedge clock);
      fault_count += status_due.size();

      if (fault_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #200000;
      $display("Verification failed");
      $finish;
   end

endmodule
